// File: rtl/core/lstfi_pkg.sv
`timescale 1ns / 1ps
package lstfi_pkg;
    localparam int unsigned DefMaxElements = 1024;
    localparam int unsigned InvW = 19;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_FLIP  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;
endpackage

// File: rtl/core/lazy_segment_tree_flip_inversions.sv
`timescale 1ns / 1ps
// Range-flip inversion counter over a bit array of MAX_ELEMENTS positions.
// Elements start empty (neither zero nor one). A load writes one element, a
// flip inverts [left, right_end), a query returns the count of one-before-zero
// pairs in [left, right_end). The array is held as a direct leaf memory of
// MAX_ELEMENTS entries, swept one element per step by a single shared
// sequencer: each step reads an element, optionally rewrites it, and updates
// running zero/one/inversion counts. A load completes as it is accepted; a
// flip or query holds o_stall high until the sequencer is back in idle, and a
// query waits in its last state while an earlier result is still held.
// After reset a clearing pass writes every element empty before the first
// request is taken. Results wait in an output register.
module lazy_segment_tree_flip_inversions
    import lstfi_pkg::*;
#(
    parameter int unsigned MAX_ELEMENTS = DefMaxElements
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [1:0]      i_kind,
    input  logic [9:0]      i_index,
    input  logic            i_bit_value,
    input  logic [9:0]      i_left,
    input  logic [10:0]     i_right_end,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [InvW-1:0] o_inversion_count
);
    localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int unsigned PW = AW + 1;
    localparam int unsigned CW = 2 * PW;

    // element code: 00 empty, 10 zero, 11 one
    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_STEP  = 6'b001000,
        S_DONE  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [PW-1:0] r_pos, n_pos;
    logic [PW-1:0] r_end, n_end;
    logic [1:0]    r_kind, n_kind;
    logic [PW-1:0] r_zeros, n_zeros;
    logic [PW-1:0] r_ones, n_ones;
    logic [CW-1:0] r_inv, n_inv;
    logic [InvW-1:0] r_res, n_res;
    logic          r_ovalid, n_ovalid;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [1:0]    wdata, rdata;

    lstfi_ram #(.Width(2), .Depth(MAX_ELEMENTS)) u_mem (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    logic [PW-1:0] clip_r, l_x;
    logic          acc;
    logic          range_ok;
    assign o_stall = (r_state != S_IDLE);
    assign acc = i_valid && (r_state == S_IDLE);
    assign l_x = PW'(i_left);
    assign clip_r = (32'(i_right_end) > MAX_ELEMENTS) ? PW'(MAX_ELEMENTS)
                                                      : PW'(i_right_end);
    // compare at full width so a left past the array never wraps
    assign range_ok = 32'(i_left) < 32'(clip_r);
    assign o_valid = r_ovalid;
    assign o_inversion_count = r_res;
    assign raddr = r_pos[AW-1:0];

    // sequencer: one element per read/step pair
    always_comb begin
        n_state = r_state;
        n_pos = r_pos;
        n_end = r_end;
        n_kind = r_kind;
        n_zeros = r_zeros;
        n_ones = r_ones;
        n_inv = r_inv;
        n_res = r_res;
        n_ovalid = r_ovalid && i_stall;
        we = 1'b0;
        waddr = r_pos[AW-1:0];
        wdata = 2'b00;
        unique case (r_state)
            S_CLEAR: begin
                we = 1'b1;
                n_pos = r_pos + PW'(1);
                if (r_pos == PW'(MAX_ELEMENTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (acc) begin
                    n_kind = i_kind;
                    n_zeros = '0;
                    n_ones = '0;
                    n_inv = '0;
                    if (i_kind == KIND_LOAD) begin
                        if (32'(i_index) < MAX_ELEMENTS) begin
                            we = 1'b1;
                            waddr = AW'(i_index);
                            wdata = {1'b1, i_bit_value};
                        end
                    end else if (i_kind == KIND_FLIP || i_kind == KIND_QUERY) begin
                        n_pos = l_x;
                        n_end = clip_r;
                        n_state = range_ok ? S_READ : S_DONE;
                    end
                end
            end
            S_READ: begin
                n_state = S_STEP;
            end
            S_STEP: begin
                if (r_kind == KIND_FLIP) begin
                    we = 1'b1;
                    wdata = {rdata[1], rdata[1] & ~rdata[0]};
                end else if (rdata[1]) begin
                    if (rdata[0]) begin
                        n_ones = r_ones + PW'(1);
                    end else begin
                        n_zeros = r_zeros + PW'(1);
                        n_inv = r_inv + CW'(r_ones);
                    end
                end
                n_pos = r_pos + PW'(1);
                n_state = (n_pos < r_end) ? S_READ : S_DONE;
            end
            S_DONE: begin
                if (r_kind == KIND_QUERY) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (!r_ovalid || !i_stall) begin
                    n_res = r_inv[InvW-1:0];
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_pos <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos <= n_pos;
            r_ovalid <= n_ovalid;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_end <= n_end;
        r_kind <= n_kind;
        r_zeros <= n_zeros;
        r_ones <= n_ones;
        r_inv <= n_inv;
        r_res <= n_res;
    end
endmodule

// File: rtl/core/lstfi_ram.sv
`timescale 1ns / 1ps
module lstfi_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import lstfi_pkg::*;

    localparam int unsigned NumElems = DefMaxElements;
    localparam int unsigned MaxSweep = 2 * NumElems + 8;

    // element states of the shadow array
    localparam logic [1:0] ELEM_EMPTY = 2'd0;
    localparam logic [1:0] ELEM_ZERO  = 2'd1;
    localparam logic [1:0] ELEM_ONE   = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_valid;
    logic            o_stall;
    logic [1:0]      i_kind;
    logic [9:0]      i_index;
    logic            i_bit_value;
    logic [9:0]      i_left;
    logic [10:0]     i_right_end;
    logic            o_valid;
    logic            i_stall;
    logic [InvW-1:0] o_inversion_count;

    logic [1:0]      elem_state [NumElems];
    logic [InvW-1:0] pending_counts [$];
    bit              quiet;
    int              hold_off;
    int              mismatches;
    int              checked;
    int              sent_requests;

    lazy_segment_tree_flip_inversions u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("Simulation FAILED");
        $finish;
    end

    // inversions in [lo, hi) of the shadow array
    function automatic logic [InvW-1:0] count_inversions(int lo, int hi);
        longint ones_seen;
        longint total;
        ones_seen = 0;
        total = 0;
        for (int k = lo; k < hi; k++) begin
            if (elem_state[k] == ELEM_ONE) ones_seen++;
            else if (elem_state[k] == ELEM_ZERO) total += ones_seen;
        end
        return total[InvW-1:0];
    endfunction

    // apply one accepted request to the shadow array
    task automatic predict_request(logic [1:0] kind, logic [9:0] idx, logic bv,
                                   logic [9:0] lft, logic [10:0] rgt);
        int hi;
        logic [InvW-1:0] due_count;
        hi = (rgt > NumElems) ? NumElems : int'(rgt);
        if (kind == KIND_LOAD) begin
            elem_state[idx] = bv ? ELEM_ONE : ELEM_ZERO;
        end else if (kind == KIND_FLIP) begin
            for (int k = int'(lft); k < hi; k++) begin
                if (elem_state[k] == ELEM_ONE) elem_state[k] = ELEM_ZERO;
                else if (elem_state[k] == ELEM_ZERO) elem_state[k] = ELEM_ONE;
            end
        end else if (kind == KIND_QUERY) begin
            due_count = (int'(lft) < hi) ? count_inversions(int'(lft), hi) : '0;
            pending_counts = {pending_counts, due_count};
        end
    endtask

    // send one request, with an optional idle gap first
    task automatic send_request(logic [1:0] kind, logic [9:0] idx, logic bv,
                                logic [9:0] lft, logic [10:0] rgt);
        if (!quiet && $urandom_range(99) < 29) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_kind      <= kind;
        i_index     <= idx;
        i_bit_value <= bv;
        i_left      <= lft;
        i_right_end <= rgt;
        i_valid     <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_request(kind, idx, bv, lft, rgt);
        sent_requests++;
    endtask

    // receiver: random stall, long hold-off on request, result check
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            checked++;
            if (pending_counts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d", o_inversion_count);
            end else begin
                if (o_inversion_count !== pending_counts[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("inversion_count mismatch: expected %0d got %0d",
                                 pending_counts[0], o_inversion_count);
                end
                void'(pending_counts.pop_front());
            end
        end
        if (hold_off > 0) begin
            i_stall  <= 1'b1;
            hold_off <= hold_off - 1;
        end else begin
            i_stall <= !quiet && ($urandom_range(99) < 29);
        end
    end

    function automatic logic [10:0] rand_right(int lo);
        int hi;
        if ($urandom_range(9) == 0) return 11'($urandom_range(0, 2047));
        hi = lo + $urandom_range(0, 48);
        if (hi > NumElems && $urandom_range(1)) hi = $urandom_range(NumElems, 2047);
        return 11'(hi);
    endfunction

    task automatic test_directed();
        send_request(KIND_QUERY, 0, 0, 0, 11'd1024);      // all empty
        send_request(KIND_FLIP, 0, 0, 0, 11'd1024);       // flip of empty elements
        send_request(KIND_QUERY, 0, 0, 0, 11'd2047);
        send_request(KIND_LOAD, 10'd0, 1'b1, 0, 0);
        send_request(KIND_LOAD, 10'd1023, 1'b0, 0, 0);
        send_request(KIND_QUERY, 0, 0, 0, 11'd1024);
        send_request(KIND_QUERY, 0, 0, 10'd1023, 11'd1024);
        send_request(KIND_QUERY, 0, 0, 10'd5, 11'd5);     // empty range
        send_request(KIND_QUERY, 0, 0, 10'd10, 11'd3);
        send_request(KIND_FLIP, 0, 0, 10'd900, 11'd100);  // empty flip
        send_request(KIND_FLIP, 0, 0, 0, 11'd2000);       // clipped
        send_request(KIND_QUERY, 0, 0, 0, 11'd1024);
        send_request(KIND_LOAD, 10'd0, 1'b1, 0, 0);       // reload after flip
        send_request(KIND_QUERY, 0, 0, 0, 11'd1024);
        send_request(KIND_NONE, 10'h3ff, 1'b1, 10'h3ff, 11'h7ff);
        send_request(KIND_FLIP, 0, 0, 10'd1023, 11'd1024);
        send_request(KIND_QUERY, 0, 0, 10'd512, 11'd1024);
    endtask

    // half ones then half zeros: a large count
    task automatic test_large_count();
        for (int k = 0; k < NumElems; k++)
            send_request(KIND_LOAD, 10'(k), 1'b1, 0, 0);
        send_request(KIND_FLIP, 0, 0, 10'd512, 11'd1024);
        send_request(KIND_QUERY, 0, 0, 0, 11'd1024);
        send_request(KIND_FLIP, 0, 0, 0, 11'd1024);
        send_request(KIND_QUERY, 0, 0, 0, 11'd1024);
    endtask

    task automatic test_backpressure();
        hold_off = 400;
        for (int n = 0; n < 12; n++)
            send_request(KIND_QUERY, 0, 0, 10'($urandom_range(0, 1000)), 11'd1024);
    endtask

    task automatic test_random(int count);
        int pick;
        int lo;
        for (int n = 0; n < count; n++) begin
            quiet = (n >= 80 && n < 200);
            pick = $urandom_range(99);
            lo = (pick % 8 == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 1023);
            if (pick < 40)
                send_request(KIND_LOAD, 10'($urandom), 1'($urandom), 10'($urandom),
                             11'($urandom));
            else if (pick < 65)
                send_request(KIND_FLIP, 10'($urandom), 1'($urandom), 10'(lo), rand_right(lo));
            else if (pick < 96)
                send_request(KIND_QUERY, 10'($urandom), 1'($urandom), 10'(lo),
                             rand_right(lo));
            else
                send_request(KIND_NONE, 10'($urandom), 1'($urandom), 10'(lo),
                             rand_right(lo));
        end
        quiet = 1'b0;
    endtask

    initial begin
        int waited;
        for (int k = 0; k < NumElems; k++) elem_state[k] = ELEM_EMPTY;
        quiet = 1'b0;
        hold_off = 0;
        mismatches = 0;
        checked = 0;
        sent_requests = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_kind = KIND_LOAD;
        i_index = '0;
        i_bit_value = 1'b0;
        i_left = '0;
        i_right_end = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_random(240);
        test_large_count();
        i_valid <= 1'b0;

        // drain outstanding results, then let the sweep settle
        waited = 0;
        while (pending_counts.size() != 0 && waited < 100 * MaxSweep) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (MaxSweep) @(posedge i_clk);
        if (pending_counts.size() != 0) begin
            mismatches++;
            $display("%0d expected results never arrived", pending_counts.size());
        end

        $display("Covered %0d requests (loads, flips, queries, ignored kinds), %0d results",
                 sent_requests, checked);
        $display("checked, with clipped and empty ranges and a long output hold-off.");
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// File: filelist.f
rtl/core/lstfi_pkg.sv
rtl/core/lstfi_ram.sv
rtl/core/lazy_segment_tree_flip_inversions.sv
tb/sv/testbench.sv
